### src/lif_neuron_refractory_update_top_macros.svh
// Assertion macros used by the LIF neuron top level.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef LIF_NEURON_REFRACTORY_UPDATE_TOP_MACROS_SVH
`define LIF_NEURON_REFRACTORY_UPDATE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LIFNR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LIFNR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lifnr_pkg.sv
// Shared types and constants for the LIF neuron block.
// No dependencies; used by the core datapath and the top level.
package lifnr_pkg;

  typedef enum logic [1:0] {
    CMD_STEP  = 2'd0,
    CMD_FIRE  = 2'd1,
    CMD_CLEAR = 2'd2
  } lifnr_cmd_t;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_NEURON_TYPE  = 3'd0;
  localparam logic [2:0] REG_LEAK_FACTOR  = 3'd1;
  localparam logic [2:0] REG_REST_DRIVE   = 3'd2;
  localparam logic [2:0] REG_CURRENT_GAIN = 3'd3;
  localparam logic [2:0] REG_THRESHOLD    = 3'd4;
  localparam logic [2:0] REG_REST_POT     = 3'd5;
  localparam logic [2:0] REG_REFR_PERIOD  = 3'd6;

  localparam int unsigned ADDR_W = 5;

  typedef struct packed {
    logic        neuron_type;
    logic [31:0] leak_factor;
    logic [31:0] rest_drive;
    logic [31:0] current_gain;
    logic [31:0] threshold;
    logic [31:0] rest_potential;
    logic [31:0] refr_period;
  } lifnr_cfg_t;

  typedef struct packed {
    logic        spike;
    logic        held;
    logic        fire_upd;   // load last fire time with this tick
    logic [31:0] potential;  // also the new membrane value
  } lifnr_res_t;

endpackage

### src/lifnr_ifs.sv
// Valid/ready channel interfaces for the LIF neuron input and result streams.
// No dependencies.
interface lifnr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [31:0]        tick_time;
  logic signed [31:0] input_current;

  modport source (output valid, command, tick_time, input_current, input ready);
  modport sink   (input valid, command, tick_time, input_current, output ready);
endinterface

interface lifnr_out_if;
  logic               valid;
  logic               ready;
  logic               spike;
  logic signed [31:0] potential;
  logic               held_refractory;

  modport source (output valid, spike, potential, held_refractory, input ready);
  modport sink   (input valid, spike, potential, held_refractory, output ready);
endinterface

### src/lif_neuron_refractory_update_top.sv
// Top level of the LIF neuron: channels, APB register file, pipeline and state.
// Depends on lifnr_pkg, lifnr_ifs and lifnr_core; assertions use the macros header.
//
// Usage:
//   in_ch  : valid/ready stream of {command, tick_time, input_current}. One
//            transaction per simulation tick; command 0 steps, 1 forces a spike,
//            2 clears the potential to rest.
//   out_ch : valid/ready stream of {spike, potential, held_refractory}, exactly
//            one result transaction per input transaction, in order.
//   APB    : seven 32-bit registers at byte address 4*index; writes land on the
//            access cycle, pready is tied high. Write only while the block is idle.
// Timing: an accepted item sits in the input register, is computed combinationally
//   (two 32x32 multiplies, add, saturate, compare) and its result is registered in
//   the result register. Throughput is one item per cycle unless out_ch stalls;
//   the limit is the membrane feedback loop through the leak multiplier.
// Reset (rst_n low, synchronous): registers, membrane and last fire time go to
//   zero and both stages empty. When out_ch stalls, the result register holds,
//   one more item is taken into the input register, then in_ch.ready drops.
`include "lif_neuron_refractory_update_top_macros.svh"

module lif_neuron_refractory_update_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lifnr_in_if.sink                      in_ch,
  lifnr_out_if.source                   out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lifnr_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import lifnr_pkg::*;

  // ---------------- configuration registers ----------------
  lifnr_cfg_t cfg_r;
  logic       cfg_we;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_NEURON_TYPE:  cfg_r.neuron_type    <= pwdata[0];
        REG_LEAK_FACTOR:  cfg_r.leak_factor    <= pwdata;
        REG_REST_DRIVE:   cfg_r.rest_drive     <= pwdata;
        REG_CURRENT_GAIN: cfg_r.current_gain   <= pwdata;
        REG_THRESHOLD:    cfg_r.threshold      <= pwdata;
        REG_REST_POT:     cfg_r.rest_potential <= pwdata;
        REG_REFR_PERIOD:  cfg_r.refr_period    <= pwdata;
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_NEURON_TYPE:  prdata = {31'd0, cfg_r.neuron_type};
      REG_LEAK_FACTOR:  prdata = cfg_r.leak_factor;
      REG_REST_DRIVE:   prdata = cfg_r.rest_drive;
      REG_CURRENT_GAIN: prdata = cfg_r.current_gain;
      REG_THRESHOLD:    prdata = cfg_r.threshold;
      REG_REST_POT:     prdata = cfg_r.rest_potential;
      REG_REFR_PERIOD:  prdata = cfg_r.refr_period;
      default:          prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  logic               s1_valid_r;
  logic [1:0]         s1_cmd_r;
  logic [31:0]        s1_tick_r;
  logic signed [31:0] s1_cur_r;
  logic               s1_adv;     // input register moves into result register
  logic               in_ready;
  logic               in_take;

  // ---------------- result register and neuron state ----------------
  logic               out_valid_r;
  logic               out_spike_r;
  logic               out_held_r;
  logic signed [31:0] out_pot_r;
  logic signed [31:0] membrane_r;
  logic signed [31:0] membrane_nxt;
  logic [31:0]        last_fire_r;
  lifnr_res_t         res;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r  <= in_ch.command;
      s1_tick_r <= in_ch.tick_time;
      s1_cur_r  <= in_ch.input_current;
    end
  end

  lifnr_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .cfg            (cfg_r),
    .command        (s1_cmd_r),
    .tick_time      (s1_tick_r),
    .input_current  (s1_cur_r),
    .membrane       (membrane_r),
    .last_fire_time (last_fire_r),
    .res            (res)
  );

  assign membrane_nxt = res.potential;

  // state commits together with the result register, so the next item
  // in the input register already sees the updated membrane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      membrane_r  <= '0;
      last_fire_r <= '0;
    end else if (s1_adv) begin
      membrane_r <= membrane_nxt;
      if (res.fire_upd) begin
        last_fire_r <= s1_tick_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_spike_r <= res.spike;
      out_held_r  <= res.held;
      out_pot_r   <= res.potential;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.spike           = out_spike_r;
  assign out_ch.held_refractory = out_held_r;
  assign out_ch.potential       = out_pot_r;

  // ---------------- assertions ----------------
  `LIFNR_ASSERT_IMP(a_pot_is_membrane, out_valid_r, out_pot_r == membrane_r, "stale potential")
  `LIFNR_ASSERT_IMP(a_spike_xor_held, out_valid_r, !(out_spike_r && out_held_r), "spike+hold")
  `LIFNR_ASSERT_NXT(a_adv_fills_out, s1_adv, out_valid_r, "result register not filled")
  `LIFNR_ASSERT_NXT(a_fire_time_hold, !s1_adv, $stable(last_fire_r), "last fire time changed")

endmodule

### src/lifnr_core.sv
// Combinational neuron update: leak and current products, saturation,
// threshold and refractory decision. Depends on lifnr_pkg.
module lifnr_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  lifnr_pkg::lifnr_cfg_t cfg,
  input  logic [1:0]            command,
  input  logic [31:0]           tick_time,
  input  logic signed [31:0]    input_current,
  input  logic signed [31:0]    membrane,
  input  logic [31:0]           last_fire_time,
  output lifnr_pkg::lifnr_res_t res
);
  import lifnr_pkg::*;

  localparam int unsigned SH_W  = 64 - FRAC_BITS;
  localparam int unsigned SUM_W = SH_W + 2;

  lifnr_cmd_t          cmd;
  logic signed [63:0]  prod_leak;
  logic signed [63:0]  prod_cur;
  logic signed [SH_W-1:0]  sh_leak;
  logic signed [SH_W-1:0]  sh_cur;
  logic signed [SUM_W-1:0] sum;
  logic [31:0]         sat;
  logic [31:0]         dt;
  logic                refr_hold;
  logic                over_thr;

  assign cmd = lifnr_cmd_t'(command);

  // arithmetic shift of the exact product is floor division
  assign prod_leak = $signed(cfg.leak_factor) * membrane;
  assign prod_cur  = $signed(cfg.current_gain) * input_current;
  assign sh_leak   = SH_W'(prod_leak >>> FRAC_BITS);
  assign sh_cur    = SH_W'(prod_cur >>> FRAC_BITS);
  assign sum = SUM_W'(sh_leak) + SUM_W'(sh_cur) + SUM_W'($signed(cfg.rest_drive));

  always_comb begin
    if (sum[SUM_W-1:31] == '0 || sum[SUM_W-1:31] == '1) begin
      sat = sum[31:0];
    end else if (sum[SUM_W-1]) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'h7FFF_FFFF;
    end
  end

  assign over_thr  = $signed(sat) >= $signed(cfg.threshold);
  assign dt        = tick_time - last_fire_time;  // wraps mod 2^32
  assign refr_hold = cfg.neuron_type && (dt <= cfg.refr_period);

  always_comb begin
    res.spike     = 1'b0;
    res.held      = 1'b0;
    res.fire_upd  = 1'b0;
    res.potential = membrane;
    unique case (cmd)
      CMD_FIRE: begin
        res.potential = cfg.rest_potential;
        res.spike     = 1'b1;
        res.fire_upd  = 1'b1;
      end
      CMD_CLEAR: begin
        res.potential = cfg.rest_potential;
      end
      CMD_STEP: begin
        if (refr_hold) begin
          res.potential = cfg.rest_potential;
          res.held      = 1'b1;
        end else if (over_thr) begin
          res.potential = cfg.rest_potential;
          res.spike     = 1'b1;
          res.fire_upd  = cfg.neuron_type;
        end else begin
          res.potential = sat;
        end
      end
      default: begin
        // reserved command: state untouched, potential reports membrane
        res.potential = membrane;
      end
    endcase
  end

endmodule

### bench/lif_neuron_refractory_update_top_tb.sv
// Self-checking bench for the LIF neuron block: directed table, then random phases.
// Depends on lifnr_pkg, lifnr_ifs and lif_neuron_refractory_update_top from src.
module lif_neuron_refractory_update_top_tb;
  import lifnr_pkg::*;

  localparam int unsigned FRAC_BITS       = 16;
  localparam logic [1:0]  CMD_UNUSED      = 2'd3;  // undefined command, must be ignored
  localparam int unsigned PHASES          = 12;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned SETTLE_CYCLES   = 4;

  // One neuron update as seen on the result channel.
  typedef struct packed {
    logic        spike;
    logic [31:0] potential;
    logic        held;
  } neuron_upd_t;

  // A row of the directed table: a register write, or an input transaction with an
  // optional hand-written result.
  typedef struct packed {
    logic        is_write;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    logic [1:0]  command;
    logic [31:0] tick;
    logic [31:0] current;
    logic        typed;
    neuron_upd_t result;
  } drill_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  lifnr_in_if  in_ch();
  lifnr_out_if out_ch();

  lif_neuron_refractory_update_top #(
    .FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // Shadow of the register file and of the neuron state, kept by the input monitor.
  logic        cfg_type   = 1'b0;
  logic [31:0] cfg_leak   = '0;
  logic [31:0] cfg_drive  = '0;
  logic [31:0] cfg_gain   = '0;
  logic [31:0] cfg_thresh = '0;
  logic [31:0] cfg_rest   = '0;
  logic [31:0] cfg_period = '0;
  logic [31:0] membrane   = '0;
  logic [31:0] last_fire  = '0;

  neuron_upd_t updates_due[$];   // predicted results, oldest first
  drill_row_t  drill[$];
  int unsigned errors = 0;
  logic        no_idle = 1'b0;   // both sides run flat out while set

  // Hand-written result riding alongside the transaction; sampled at accept.
  logic        typed_pending;
  neuron_upd_t typed_res;

  // Neuron update for one accepted transaction. Products are exact in 64 bits and
  // floored by the arithmetic shift; the sum saturates once to 32 bits.
  function automatic neuron_upd_t advance_neuron(logic [1:0] cmd, logic [31:0] tick,
                                                 logic [31:0] cur);
    neuron_upd_t upd;
    longint      leak_term;
    longint      current_term;
    longint      total;
    logic [31:0] since_fire;
    logic [31:0] v;
    upd = '0;
    case (cmd)
      CMD_FIRE: begin
        membrane  = cfg_rest;
        last_fire = tick;
        upd.spike = 1'b1;
      end
      CMD_CLEAR: membrane = cfg_rest;
      CMD_STEP: begin
        since_fire = tick - last_fire;  // wraps mod 2^32
        if (cfg_type && since_fire <= cfg_period) begin
          membrane = cfg_rest;
          upd.held = 1'b1;
        end else begin
          leak_term    = (longint'($signed(cfg_leak)) * longint'($signed(membrane)))
                         >>> FRAC_BITS;
          current_term = (longint'($signed(cfg_gain)) * longint'($signed(cur)))
                         >>> FRAC_BITS;
          total = leak_term + longint'($signed(cfg_drive)) + current_term;
          if (total > 64'sh7FFF_FFFF) begin
            v = 32'h7FFF_FFFF;
          end else if (total < -64'sh8000_0000) begin
            v = 32'h8000_0000;
          end else begin
            v = total[31:0];
          end
          if ($signed(v) >= $signed(cfg_thresh)) begin
            v         = cfg_rest;
            upd.spike = 1'b1;
            // plain mode never records a natural spike
            if (cfg_type) last_fire = tick;
          end
          membrane = v;
        end
      end
      default: ;  // unused command leaves everything alone
    endcase
    upd.potential = membrane;
    return upd;
  endfunction

  function automatic void apply_reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    case (addr[ADDR_W-1:2])
      REG_NEURON_TYPE:  cfg_type   = data[0];
      REG_LEAK_FACTOR:  cfg_leak   = data;
      REG_REST_DRIVE:   cfg_drive  = data;
      REG_CURRENT_GAIN: cfg_gain   = data;
      REG_THRESHOLD:    cfg_thresh = data;
      REG_REST_POT:     cfg_rest   = data;
      REG_REFR_PERIOD:  cfg_period = data;
      default: ;
    endcase
  endfunction

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [31:0] corner_value();
    case ($urandom_range(0, 4))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0001_0000;
    endcase
  endfunction

  // mode 0: values of a working neuron, 1: corners, 2: anything
  function automatic logic [31:0] draw_setting(logic [2:0] idx, int unsigned mode);
    if (idx == REG_NEURON_TYPE) return $urandom_range(0, 1);
    if (mode == 1) return corner_value();
    if (mode == 2) return $urandom();
    case (idx)
      REG_LEAK_FACTOR:  return $urandom_range(0, 32'h1_0000);
      REG_REST_DRIVE:   return $urandom_range(0, 32'h2000) - 32'h1000;
      REG_CURRENT_GAIN: return $urandom_range(32'h8000, 32'h2_0000);
      REG_THRESHOLD:    return $urandom_range(32'h1_0000, 32'h8_0000);
      REG_REST_POT:     return $urandom_range(0, 32'h2_0000) - 32'h1_0000;
      default:          return $urandom_range(0, 20);
    endcase
  endfunction

  // Input side monitor: predict on every accepted transaction, track register writes.
  always @(posedge clk) begin : input_monitor
    neuron_upd_t upd;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      upd = advance_neuron(in_ch.command, in_ch.tick_time, in_ch.input_current);
      updates_due.push_back(typed_pending ? typed_res : upd);
    end
    if (rst_n && psel && penable && pwrite && pready) apply_reg_write(paddr, pwdata);
  end

  // Result side: every accepted result must match the oldest prediction.
  always @(posedge clk) begin : result_check
    neuron_upd_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (updates_due.size() == 0) begin
        $error("result transaction with nothing pending: spike %0d potential %h held %0d",
               out_ch.spike, out_ch.potential, out_ch.held_refractory);
        errors++;
      end else begin
        want = updates_due.pop_front();
        if (out_ch.spike !== want.spike) begin
          $error("spike: expected %0d, got %0d", want.spike, out_ch.spike);
          errors++;
        end
        if (out_ch.potential !== want.potential) begin
          $error("potential: expected %h, got %h", want.potential, out_ch.potential);
          errors++;
        end
        if (out_ch.held_refractory !== want.held) begin
          $error("held_refractory: expected %0d, got %0d", want.held,
                 out_ch.held_refractory);
          errors++;
        end
      end
    end
  end

  // Result receiver: random stall before each result, none while no_idle is set.
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // APB write: setup cycle, access cycle, then psel low before returning so that the next
  // write starts in a later time step.
  task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Sends one transaction after a random gap; returns at the accepting edge with
  // valid still high so a back-to-back transaction never toggles it.
  task automatic send_item(logic [1:0] cmd, logic [31:0] tick, logic [31:0] cur,
                           logic typed, neuron_upd_t res);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.tick_time     <= tick;
    in_ch.input_current <= cur;
    typed_pending       <= typed;
    typed_res           <= res;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop sending and wait for every predicted result; the block is idle afterwards.
  task automatic settle_outputs();
    int unsigned waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (updates_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (updates_due.size() != 0) begin
      $error("%0d result transactions never arrived", updates_due.size());
      errors++;
      updates_due.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_write(logic [2:0] idx, logic [31:0] value);
    drill.push_back({1'b1, idx, value, CMD_UNUSED, 32'd0, 32'd0, 1'b0, 34'd0});
  endtask

  task automatic add_item(logic [1:0] cmd, logic [31:0] tick, logic [31:0] cur);
    drill.push_back({1'b0, 3'd0, 32'd0, cmd, tick, cur, 1'b0, 34'd0});
  endtask

  task automatic add_checked(logic [1:0] cmd, logic [31:0] tick, logic [31:0] cur,
                             logic spike, logic [31:0] pot, logic held);
    drill.push_back({1'b0, 3'd0, 32'd0, cmd, tick, cur, 1'b1, spike, pot, held});
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    int unsigned mode;
    int unsigned r;
    logic [1:0]  cmd;
    logic [31:0] cur;
    logic [31:0] tick_now;

    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CMD_STEP;
    in_ch.tick_time     <= '0;
    in_ch.input_current <= '0;
    typed_pending       <= 1'b0;
    typed_res           <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table. All registers are zero out of reset.
    // Refractory mode right after reset: tick 0 is within a zero period of
    // the reset fire time, so the first step is held.
    add_write(REG_NEURON_TYPE, 32'd1);
    add_checked(CMD_STEP, 32'd0, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b1);
    add_write(REG_NEURON_TYPE, 32'd0);
    // zero gains: potential 0 meets threshold 0, fires to rest
    add_checked(CMD_STEP, 32'd0, 32'h7FFF_FFFF, 1'b1, 32'h0, 1'b0);
    add_checked(CMD_UNUSED, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 1'b0);
    add_write(REG_LEAK_FACTOR, 32'h0001_0000);
    add_write(REG_CURRENT_GAIN, 32'h0001_0000);
    add_write(REG_THRESHOLD, 32'h7FFF_FFFF);
    add_write(REG_REST_POT, 32'hFFFF_0000);
    // unity gain, max current reaches the max threshold exactly
    add_checked(CMD_STEP, 32'd1, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_0000, 1'b0);
    add_checked(CMD_CLEAR, 32'd2, 32'h1234_5678, 1'b0, 32'hFFFF_0000, 1'b0);
    // negative saturation
    add_checked(CMD_STEP, 32'd3, 32'h8000_0000, 1'b0, 32'h8000_0000, 1'b0);
    add_item(CMD_STEP, 32'd4, 32'h8000_0000);
    add_write(REG_REST_DRIVE, 32'h7FFF_FFFF);
    add_item(CMD_STEP, 32'd5, 32'h7FFF_FFFF);
    add_write(REG_LEAK_FACTOR, 32'h8000_0000);
    add_write(REG_CURRENT_GAIN, 32'h8000_0000);
    add_write(REG_REST_DRIVE, 32'h8000_0000);
    add_item(CMD_STEP, 32'd6, 32'h8000_0000);
    // smallest negative gain: floor rounding shows on a unit current
    add_write(REG_CURRENT_GAIN, 32'hFFFF_FFFF);
    add_item(CMD_STEP, 32'd7, 32'h0000_0001);
    add_checked(CMD_FIRE, 32'd100, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_0000, 1'b0);
    add_write(REG_NEURON_TYPE, 32'd1);
    add_write(REG_REFR_PERIOD, 32'd10);
    add_checked(CMD_STEP, 32'd105, 32'h0, 1'b0, 32'hFFFF_0000, 1'b1);
    add_checked(CMD_STEP, 32'd110, 32'h0, 1'b0, 32'hFFFF_0000, 1'b1);  // edge of period
    add_item(CMD_STEP, 32'd111, 32'h4000_0000);
    add_checked(CMD_CLEAR, 32'd112, 32'h0, 1'b0, 32'hFFFF_0000, 1'b0);
    // min threshold fires on every step not held; zero period holds only the same tick
    add_write(REG_THRESHOLD, 32'h8000_0000);
    add_write(REG_REFR_PERIOD, 32'd0);
    add_checked(CMD_STEP, 32'd300, 32'd5, 1'b1, 32'hFFFF_0000, 1'b0);
    add_checked(CMD_STEP, 32'd300, 32'd5, 1'b0, 32'hFFFF_0000, 1'b1);
    add_write(REG_REFR_PERIOD, 32'hFFFF_FFFF);
    add_checked(CMD_STEP, 32'h89AB_CDEF, 32'h0, 1'b0, 32'hFFFF_0000, 1'b1);
    // time difference wrapping past zero
    add_checked(CMD_FIRE, 32'hFFFF_FFF0, 32'h0, 1'b1, 32'hFFFF_0000, 1'b0);
    add_write(REG_REFR_PERIOD, 32'h20);
    add_checked(CMD_STEP, 32'h0000_0005, 32'h0, 1'b0, 32'hFFFF_0000, 1'b1);
    add_checked(CMD_STEP, 32'h0000_0011, 32'h0, 1'b1, 32'hFFFF_0000, 1'b0);
    add_write(REG_NEURON_TYPE, 32'd0);
    add_checked(CMD_STEP, 32'h0000_0012, 32'h0, 1'b1, 32'hFFFF_0000, 1'b0);
    add_write(REG_REST_POT, 32'h7FFF_FFFF);
    add_checked(CMD_CLEAR, 32'd0, 32'hFFFF_FFFF, 1'b0, 32'h7FFF_FFFF, 1'b0);
    add_checked(CMD_UNUSED, 32'd9, 32'h0, 1'b0, 32'h7FFF_FFFF, 1'b0);

    foreach (drill[i]) begin
      if (drill[i].is_write) begin
        settle_outputs();
        cfg_write(drill[i].reg_idx, drill[i].reg_val);
      end else begin
        send_item(drill[i].command, drill[i].tick, drill[i].current, drill[i].typed,
                  drill[i].result);
      end
    end

    // Random phases. Each starts from an idle block with a fresh register set: half
    // of the phases a working neuron, the others with corner or arbitrary settings.
    tick_now = $urandom();
    for (phase = 0; phase < PHASES; phase++) begin
      settle_outputs();
      mode = (phase % 4 == 1) ? 1 : (phase % 4 == 3) ? 2 : 0;
      for (int idx = 0; idx < 7; idx++) begin
        cfg_write(3'(idx), draw_setting(3'(idx), mode));
      end
      no_idle = (phase % 3 == 2);
      if (phase % 4 == 1) tick_now = 32'hFFFF_FF80;  // run through the wrap
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        cmd = (r < 80) ? CMD_STEP : (r < 88) ? CMD_FIRE : (r < 94) ? CMD_CLEAR : CMD_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 85) begin
          tick_now += 1;
        end else if (r < 95) begin
          tick_now += $urandom_range(0, 40);
        end else begin
          tick_now = $urandom();
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
          cur = $urandom_range(0, 32'h4_0000) - 32'h1_0000;
        end else if (r < 90) begin
          cur = $urandom();
        end else begin
          cur = corner_value();
        end
        send_item(cmd, tick_now, cur, 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    settle_outputs();
    if (errors == 0) begin
      $display("lif_neuron_refractory_update_top_tb: done, clean");
    end else begin
      $display("lif_neuron_refractory_update_top_tb: done, errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #800_000;
    $display("lif_neuron_refractory_update_top_tb: done, errors");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/lifnr_pkg.sv
src/lifnr_ifs.sv
src/lifnr_core.sv
src/lif_neuron_refractory_update_top.sv
bench/lif_neuron_refractory_update_top_tb.sv
